[hdl/oets_pkg.sv]
// shared types, constants and helpers for the odd-even transposition sorter
`default_nettype none

package oets_pkg;

	localparam int ENTRIES    = 64;
	localparam int DATA_WIDTH = 32;
	localparam int IO_WIDTH   = 32;
	localparam int CNT_W      = $clog2(ENTRIES + 1);

	typedef logic signed [DATA_WIDTH-1:0] data_t;
	typedef logic signed [IO_WIDTH-1:0]   io_word_t;
	typedef logic [CNT_W-1:0]             count_t;

	typedef enum logic [1:0] {
		OP_HOLD,
		OP_LOAD,
		OP_SORT,
		OP_UNLOAD
	} cell_op_t;

	typedef enum logic [1:0] {
		ST_LOAD,
		ST_SORT,
		ST_UNLOAD
	} sort_state_t;

	typedef struct packed {
		cell_op_t op;
		logic     pair_en;
	} cell_cmd_t;

	// wrap an input word to the storage width, two's complement
	function automatic data_t to_store(input io_word_t w);
		logic signed [63:0] ext;
		begin
			ext = 64'(w);
			return ext[DATA_WIDTH-1:0];
		end
	endfunction

	// sign-extend a stored element back to the port width
	function automatic io_word_t to_port(input data_t d);
		logic signed [63:0] ext;
		begin
			ext = 64'(d);
			return ext[IO_WIDTH-1:0];
		end
	endfunction

endpackage

`default_nettype wire

[hdl/odd_even_transposition_sort_unit.sv]
// top level of the odd-even transposition sorter: cell chain and sequencer
// load: one cycle per input word, words shift into the chain at cell 0
// sort: n compare-exchange phases for n stored words, one per cycle
// unload: one cycle per output word while out_ready is high, the chain shifts toward cell 0
// reset clears the sequencer, fill count and drop flag; cell contents are not reset
`default_nettype none

module odd_even_transposition_sort_unit (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire                    in_valid,
	output logic                   in_ready,
	input  oets_pkg::io_word_t     value,
	input  wire                    last,
	output logic                   out_valid,
	input  wire                    out_ready,
	output oets_pkg::io_word_t     sorted_value,
	output logic                   final_res,
	output logic                   overflowed
);
	import oets_pkg::*;

	sort_state_t state_q, state_d;
	count_t      count_q, count_d;
	count_t      phase_q, phase_d;
	logic        dropped_q, dropped_d;
	cell_op_t    op;

	// chain wiring, one slot per cell
	data_t       cell_val  [ENTRIES];
	logic        cell_swap [ENTRIES];
	cell_cmd_t   cell_cmd  [ENTRIES];

	logic        in_fire, out_fire, full;
	logic        odd_phase;

	// input is taken only while loading, results offered only while unloading
	assign in_ready  = (state_q == ST_LOAD);
	assign out_valid = (state_q == ST_UNLOAD);
	assign full      = (count_q == count_t'(ENTRIES));
	assign in_fire   = in_valid && in_ready;
	assign out_fire  = out_valid && out_ready;
	// first phase of a pass pairs (1,2),(3,4),..., second pairs (0,1),(2,3),...
	assign odd_phase = ~phase_q[0];

	// next state and chain command
	always_comb begin
		state_d   = state_q;
		count_d   = count_q;
		phase_d   = phase_q;
		dropped_d = dropped_q;
		op        = OP_HOLD;
		case (state_q)
			ST_LOAD: begin
				if (in_fire) begin
					if (full) begin
						// buffer full, word is dropped
						dropped_d = 1'b1;
					end else begin
						op      = OP_LOAD;
						count_d = count_q + count_t'(1);
					end
					if (last) begin
						state_d = ST_SORT;
						phase_d = '0;
					end
				end
			end
			ST_SORT: begin
				// n phases sort any n elements
				op      = OP_SORT;
				phase_d = phase_q + count_t'(1);
				if (phase_q + count_t'(1) >= count_q) begin
					state_d = ST_UNLOAD;
				end
			end
			ST_UNLOAD: begin
				if (out_fire) begin
					op      = OP_UNLOAD;
					count_d = count_q - count_t'(1);
					if (count_q == count_t'(1)) begin
						state_d   = ST_LOAD;
						dropped_d = 1'b0;
					end
				end
			end
			default: begin
				state_d = ST_LOAD;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_LOAD;
			count_q   <= '0;
			phase_q   <= '0;
			dropped_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			count_q   <= count_d;
			phase_q   <= phase_d;
			dropped_q <= dropped_d;
		end
	end

	// the cell chain; a pair is live when its parity matches and both slots hold data
	for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
		data_t left_v, right_v;
		logic  swap_l;

		assign cell_cmd[i].op      = op;
		if (i + 1 < ENTRIES) begin : g_pair
			assign cell_cmd[i].pair_en = (1'(i % 2) == odd_phase)
				&& (count_q > count_t'(i + 1));
			assign right_v = cell_val[i+1];
		end else begin : g_end
			assign cell_cmd[i].pair_en = 1'b0;
			assign right_v = '0;
		end
		if (i == 0) begin : g_head
			// new words enter at the head of the chain
			assign left_v = to_store(value);
			assign swap_l = 1'b0;
		end else begin : g_body
			assign left_v = cell_val[i-1];
			assign swap_l = cell_swap[i-1];
		end

		oets_cell u_cell (
			.clk       (clk),
			.cmd       (cell_cmd[i]),
			.left_val  (left_v),
			.right_val (right_v),
			.swap_in   (swap_l),
			.swap_out  (cell_swap[i]),
			.value     (cell_val[i])
		);
	end

	// results come straight from the head cell register
	assign sorted_value = to_port(cell_val[0]);
	assign final_res    = (count_q == count_t'(1));
	assign overflowed   = dropped_q;

endmodule

`default_nettype wire

[hdl/oets_cell.sv]
// one element cell of the sorting chain with its compare-exchange logic
`default_nettype none

module oets_cell (
	input  wire                    clk,
	input  oets_pkg::cell_cmd_t    cmd,
	input  oets_pkg::data_t        left_val,
	input  oets_pkg::data_t        right_val,
	input  wire                    swap_in,
	output logic                   swap_out,
	output oets_pkg::data_t        value
);
	import oets_pkg::*;

	data_t value_q;

	// pair with the right neighbor swaps when this element is larger
	assign swap_out = cmd.pair_en && (value_q > right_val);
	assign value    = value_q;

	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_LOAD: begin
				value_q <= left_val;
			end
			OP_SORT: begin
				if (swap_out) begin
					value_q <= right_val;
				end else if (swap_in) begin
					value_q <= left_val;
				end
			end
			OP_UNLOAD: begin
				value_q <= right_val;
			end
			default: begin
				value_q <= value_q;
			end
		endcase
	end

endmodule

`default_nettype wire

[verif/tb_top.sv]
// self-checking testbench for the odd-even transposition sort unit
module tb_top;
	import oets_pkg::*;

	// one expected output word: value, end-of-set mark, drop flag
	typedef struct {
		io_word_t word;
		logic     fin;
		logic     ovf;
	} sorted_word_t;

	// directed table row; known rows carry the output typed in by hand
	typedef struct {
		io_word_t v;
		logic     l;
		logic     known;
		io_word_t kv;
	} dir_row_t;

	localparam int DIR_ROWS = 22;
	localparam int PHASE_WORDS = 96;
	localparam int DRAIN_CYCLES = 200;

	logic     clk = 1'b0;
	logic     arst_n;
	logic     in_valid;
	logic     in_ready;
	io_word_t value;
	logic     last;
	logic     out_valid;
	logic     out_ready;
	io_word_t sorted_value;
	logic     final_res;
	logic     overflowed;

	odd_even_transposition_sort_unit u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.value       (value),
		.last        (last),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.sorted_value(sorted_value),
		.final_res   (final_res),
		.overflowed  (overflowed)
	);

	// 20-unit clock period
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// shadow copy of the sorter state
	data_t       set_store [ENTRIES];
	int          set_fill;
	logic        set_dropped;
	sorted_word_t pending_sorted [$];

	// run statistics
	int mismatch_count;
	int words_sent;
	int words_returned;
	int sets_closed;
	int overflow_sets;
	int sender_idle_pct;
	int receiver_idle_pct;

	// the expected word under check, taken from the front of the queue
	sorted_word_t head_word;

	// directed stimulus: single-word sets at the extremes, reversed pair,
	// duplicates, mixed signs with repeats, presorted run, alternating bits
	dir_row_t dir_rows [DIR_ROWS] = '{
		'{32'h7fffffff, 1'b1, 1'b1, 32'h7fffffff},
		'{32'h80000000, 1'b1, 1'b1, 32'h80000000},
		'{32'h00000000, 1'b1, 1'b1, 32'h00000000},
		'{32'hffffffff, 1'b1, 1'b1, 32'hffffffff},
		'{32'h7fffffff, 1'b0, 1'b0, 32'h0},
		'{32'h80000000, 1'b1, 1'b0, 32'h0},
		'{32'h00000005, 1'b0, 1'b0, 32'h0},
		'{32'h00000005, 1'b0, 1'b0, 32'h0},
		'{32'h00000005, 1'b1, 1'b0, 32'h0},
		'{32'h00000064, 1'b0, 1'b0, 32'h0},
		'{32'hfffffffd, 1'b0, 1'b0, 32'h0},
		'{32'h7fffffff, 1'b0, 1'b0, 32'h0},
		'{32'h00000000, 1'b0, 1'b0, 32'h0},
		'{32'h80000000, 1'b0, 1'b0, 32'h0},
		'{32'hfffffffd, 1'b1, 1'b0, 32'h0},
		'{32'h00000001, 1'b0, 1'b0, 32'h0},
		'{32'h00000002, 1'b0, 1'b0, 32'h0},
		'{32'h00000003, 1'b0, 1'b0, 32'h0},
		'{32'h00000004, 1'b1, 1'b0, 32'h0},
		'{32'h55555555, 1'b0, 1'b0, 32'h0},
		'{32'haaaaaaaa, 1'b0, 1'b0, 32'h0},
		'{32'h00000001, 1'b1, 1'b0, 32'h0}
	};

	task automatic flag_error(input string msg);
		mismatch_count++;
		if (mismatch_count <= 10) begin
			$display("[%0t] mismatch: %s", $realtime, msg);
		end
	endtask

	// store one accepted word; on the set's last word run the odd/even
	// exchange passes until a pass swaps nothing, then queue every word
	function automatic void take_word(input io_word_t v, input logic l);
		data_t t;
		bit    swapped;
		int    i;
		int    s;
		if (set_fill < ENTRIES) begin
			set_store[set_fill] = data_t'(v);
			set_fill++;
		end else begin
			// buffer full: word is dropped, also when it closes the set
			set_dropped = 1'b1;
		end
		if (!l) return;
		do begin
			swapped = 1'b0;
			// odd pairs first, then even pairs
			for (s = 1; s >= 0; s--) begin
				for (i = s; i + 1 < set_fill; i += 2) begin
					if (set_store[i] > set_store[i+1]) begin
						t = set_store[i];
						set_store[i] = set_store[i+1];
						set_store[i+1] = t;
						swapped = 1'b1;
					end
				end
			end
		end while (swapped);
		for (i = 0; i < set_fill; i++) begin
			pending_sorted.insert(pending_sorted.size(),
				'{io_word_t'(set_store[i]), i == set_fill - 1, set_dropped});
		end
		sets_closed++;
		if (set_dropped) overflow_sets++;
		set_fill = 0;
		set_dropped = 1'b0;
	endfunction

	// mostly full-range words, with extremes and a narrow band for duplicates
	function automatic io_word_t pick_value();
		case ($urandom_range(9))
			0: begin
				case ($urandom_range(3))
					0: return 32'h7fffffff;
					1: return 32'h80000000;
					2: return 32'h00000000;
					default: return 32'hffffffff;
				endcase
			end
			1, 2: return io_word_t'($urandom_range(8)) - io_word_t'(4);
			default: return io_word_t'($urandom);
		endcase
	endfunction

	// present one word at the falling edge, hold it until the block takes it
	task automatic send_word(input io_word_t v, input logic l, input logic known = 1'b0,
		input io_word_t kv = '0);
		@(negedge clk);
		while ($urandom_range(99) < sender_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		value    <= v;
		last     <= l;
		do @(posedge clk); while (!in_ready);
		words_sent++;
		take_word(v, l);
		// single-word directed sets: check against the hand-typed word
		if (known) begin
			pending_sorted[pending_sorted.size() - 1] = '{kv, 1'b1, 1'b0};
		end
	endtask

	task automatic send_set(input int len);
		int j;
		for (j = 0; j < len; j++) begin
			send_word(pick_value(), j == len - 1);
		end
	endtask

	// sender holds off until the block has returned everything it owes
	task automatic wait_drained();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_sorted.size() != 0) @(posedge clk);
	endtask

	// receiver: ready decided each falling edge from the current stall rate
	always @(negedge clk) begin
		if (arst_n) begin
			out_ready <= ($urandom_range(99) >= receiver_idle_pct);
		end
	end

	// output check: every accepted word against the oldest expectation
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			words_returned++;
			if (pending_sorted.size() == 0) begin
				flag_error($sformatf("unexpected word %h final=%b ovf=%b",
					sorted_value, final_res, overflowed));
			end else begin
				head_word = pending_sorted.pop_front();
				if (sorted_value !== head_word.word)
					flag_error($sformatf("sorted_value exp %h got %h",
						head_word.word, sorted_value));
				if (final_res !== head_word.fin)
					flag_error($sformatf("final_res exp %b got %b (value %h)",
						head_word.fin, final_res, head_word.word));
				if (overflowed !== head_word.ovf)
					flag_error($sformatf("overflowed exp %b got %b (value %h)",
						head_word.ovf, overflowed, head_word.word));
			end
		end
	end

	// main sequence: reset, directed table, three random phases, drain
	initial begin
		int big_len [3];
		int phase;
		int phase_start;
		int r;
		bit first_set;
		arst_n            = 1'b0;
		in_valid          = 1'b0;
		value             = '0;
		last              = 1'b0;
		out_ready         = 1'b0;
		set_fill          = 0;
		set_dropped       = 1'b0;
		mismatch_count    = 0;
		words_sent        = 0;
		words_returned    = 0;
		sets_closed       = 0;
		overflow_sets     = 0;
		sender_idle_pct   = 26;
		receiver_idle_pct = 48;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		for (r = 0; r < DIR_ROWS; r++) begin
			send_word(dir_rows[r].v, dir_rows[r].l, dir_rows[r].known, dir_rows[r].kv);
		end

		// each phase opens with one large set: exactly full, full with the
		// closing word dropped, then several words dropped
		big_len[0] = ENTRIES;
		big_len[1] = ENTRIES + 1;
		big_len[2] = $urandom_range(ENTRIES + 6, ENTRIES + 2);
		for (phase = 0; phase < 3; phase++) begin
			wait_drained();
			case (phase)
				0: begin
					sender_idle_pct   = 26;
					receiver_idle_pct = 48;
				end
				1: begin
					sender_idle_pct   = 48;
					receiver_idle_pct = 26;
				end
				default: begin
					sender_idle_pct   = 0;
					receiver_idle_pct = 0;
				end
			endcase
			phase_start = words_sent;
			first_set = 1'b1;
			while (words_sent - phase_start < PHASE_WORDS) begin
				if (first_set)
					send_set(big_len[phase]);
				else if ($urandom_range(3) == 0)
					send_set($urandom_range(2, 1));
				else
					send_set($urandom_range(12, 1));
				first_set = 1'b0;
			end
		end

		wait_drained();
		// let any stray output show up before closing
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (pending_sorted.size() != 0)
			flag_error($sformatf("%0d words never returned", pending_sorted.size()));
		$display("sent %0d words in %0d sets, %0d sorted words checked, %0d sets overflowed",
			words_sent, sets_closed, words_returned, overflow_sets);
		$display("stalls: sender-light/receiver-heavy, reversed, then none; %0d mismatches",
			mismatch_count);
		if (mismatch_count == 0) begin
			$display("odd_even_transposition_sort_unit regression: pass");
		end else begin
			$display("odd_even_transposition_sort_unit regression: fail");
		end
		$finish;
	end

	// watchdog, far beyond the slowest legal run
	initial begin
		#4000000;
		$display("odd_even_transposition_sort_unit regression: fail");
		$finish;
	end

endmodule

[files.f]
hdl/oets_pkg.sv
hdl/oets_cell.sv
hdl/odd_even_transposition_sort_unit.sv
verif/tb_top.sv
